[hw/rtl/aispfe_pkg.sv]
// Package for the AIS payload field extractor: field widths, command and
// status codes, de-armoring and divide-by-six helpers.
// No dependencies.
package aispfe_pkg;

   localparam int CMD_W    = 2;
   localparam int CHAR_W   = 8;
   localparam int POS_W    = 10;
   localparam int MAXC_W   = 7;
   localparam int VALUE_W  = 32;
   localparam int TEXT_W   = 7;
   localparam int STATUS_W = 2;
   localparam int SYM_W    = 6;
   localparam int GRP_W    = 8;

   localparam int DEF_MAX_SYMBOLS      = 128;
   localparam int DEF_MAX_STRING_CHARS = 64;
   localparam int BITS_PER_SYM         = 6;

   localparam logic [CHAR_W-1:0] ARMOR_LO1  = 8'h30;
   localparam logic [CHAR_W-1:0] ARMOR_HI1  = 8'h57;
   localparam logic [CHAR_W-1:0] ARMOR_LO2  = 8'h60;
   localparam logic [CHAR_W-1:0] ARMOR_HI2  = 8'h77;
   localparam logic [CHAR_W-1:0] ARMOR_OFF2 = 8'h38;
   localparam logic [SYM_W-1:0]  SYM_BAD    = 6'h3f;
   localparam logic [SYM_W-1:0]  TEXT_LIMIT = 6'h20;
   localparam logic [TEXT_W-1:0] TEXT_RAISE = 7'h40;
   localparam logic [TEXT_W-1:0] TEXT_MIN   = 7'h20;
   localparam logic [TEXT_W-1:0] TEXT_MAX   = 7'h5f;

   // floor(x / 6) = (x * 683) >> 12 for x below 2047, then one correction
   localparam int DIV_W       = 11;
   localparam int DIV6_RECIP  = 683;
   localparam int DIV6_SHIFT  = 12;
   localparam int DIV6_PROD_W = 21;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR,
      CMD_APPEND,
      CMD_INT,
      CMD_STRING
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK,
      STATUS_BAD_CHAR,
      STATUS_FULL,
      STATUS_PAST
   } status_type;

   typedef struct packed {
      logic [GRP_W-1:0] quo;
      logic [2:0]       rem;
   } div6_type;

   typedef struct packed {
      logic             bad;
      logic [SYM_W-1:0] sym;
   } armor_type;

   function automatic armor_type dearmor(input logic [CHAR_W-1:0] c);
      armor_type        r;
      logic [CHAR_W-1:0] d;
      d = c - ARMOR_LO1;
      if (c >= ARMOR_LO2) begin
         d = c - ARMOR_OFF2;
      end
      r.bad = 1'b0;
      r.sym = d[SYM_W-1:0];
      if (c < ARMOR_LO1 || c > ARMOR_HI2 || (c > ARMOR_HI1 && c < ARMOR_LO2)) begin
         r.bad = 1'b1;
         r.sym = SYM_BAD;
      end
      return r;
   endfunction

   function automatic div6_type div6(input logic [DIV_W-1:0] x);
      div6_type                 r;
      logic [DIV6_PROD_W-1:0]   prod;
      logic [DIV_W-1:0]         rest;
      prod  = DIV6_PROD_W'(x) * DIV6_PROD_W'(DIV6_RECIP);
      r.quo = prod[DIV6_SHIFT +: GRP_W];
      rest  = DIV_W'(x - DIV_W'(r.quo) * DIV_W'(BITS_PER_SYM));
      if (rest >= DIV_W'(BITS_PER_SYM)) begin
         r.quo = GRP_W'(r.quo + 1'b1);
         rest  = DIV_W'(rest - DIV_W'(BITS_PER_SYM));
      end
      r.rem = rest[2:0];
      return r;
   endfunction

endpackage

[hw/rtl/ais_payload_field_extractor_top.sv]
// Top level of the AIS payload field extractor: symbol store, bit walker
// and result register. Depends on aispfe_pkg.
//
// A word is taken when start is high and busy is low. Clear and append
// answer with one result word in the next cycle and keep busy low, so one
// may follow each cycle. An integer query walks its field one bit a cycle
// through a single shift-and-test unit, pausing in a fetch state each time
// the walk enters a new six-bit symbol (the store read is registered). A
// string query walks six bits per character the same way and emits each
// character as it completes. Results appear for exactly one cycle with
// rsp_valid high and cannot be held off, so the receiver must take every
// strobed word. busy is high from the cycle after a non-empty query is
// taken until its last result.
module ais_payload_field_extractor_top #(
   parameter int MAX_SYMBOLS      = aispfe_pkg::DEF_MAX_SYMBOLS,
   parameter int MAX_STRING_CHARS = aispfe_pkg::DEF_MAX_STRING_CHARS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [aispfe_pkg::CMD_W-1:0]        req_command,
   input  logic [aispfe_pkg::CHAR_W-1:0]       req_char_in,
   input  logic [aispfe_pkg::POS_W-1:0]        req_start_bit,
   input  logic [aispfe_pkg::POS_W-1:0]        req_field_bits,
   input  logic                                req_signed_flag,
   input  logic [aispfe_pkg::MAXC_W-1:0]       req_max_chars,
   output logic                                rsp_valid,
   output logic signed [aispfe_pkg::VALUE_W-1:0] rsp_value,
   output logic [aispfe_pkg::TEXT_W-1:0]       rsp_text_char,
   output logic                                rsp_char_valid,
   output logic                                rsp_last,
   output logic [aispfe_pkg::POS_W-1:0]        rsp_bit_count,
   output logic [aispfe_pkg::STATUS_W-1:0]     rsp_status
);
   import aispfe_pkg::*;

   localparam int CNT_W  = $clog2(MAX_SYMBOLS + 1);
   localparam int ADDR_W = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
   localparam int IDX_W  = (CNT_W > 9) ? CNT_W : 9;
   localparam int LEN_W  = 6;
   localparam int BC_W   = CNT_W + POS_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_BITS
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [IDX_W-1:0]     sym_idx_ff, sym_idx_in;
   logic [2:0]           off_ff, off_in;
   logic                 pre_ff, pre_in;
   logic                 first_ff, first_in;
   logic                 is_str_ff, is_str_in;
   logic                 signed_ff, signed_in;
   logic                 past_ff, past_in;
   logic [VALUE_W-1:0]   acc_ff, acc_in;
   logic [LEN_W-1:0]     grp_left_ff, grp_left_in;
   logic [MAXC_W-1:0]    chars_left_ff, chars_left_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]   rsp_value_ff, rsp_value_in;
   logic [TEXT_W-1:0]    rsp_text_ff, rsp_text_in;
   logic                 rsp_cvalid_ff, rsp_cvalid_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic [POS_W-1:0]     rsp_bits_ff, rsp_bits_in;
   status_type           rsp_status_ff, rsp_status_in;

   logic [SYM_W-1:0]     mem [MAX_SYMBOLS];
   logic [SYM_W-1:0]     rd_ff;
   logic                 mem_we;

   armor_type            armor;
   div6_type             pos_div;
   div6_type             grp_div;
   logic [POS_W-1:0]     base;
   logic [MAXC_W-1:0]    nchars;
   logic [LEN_W-1:0]     ilen;
   logic                 accept;
   logic                 bit_past;
   logic                 bit_val;
   logic                 past_next;
   logic [VALUE_W-1:0]   acc_next;
   logic [TEXT_W-1:0]    text_next;

   function automatic logic [POS_W-1:0] bits_of(input logic [CNT_W-1:0] c);
      logic [BC_W-1:0] t;
      t = BC_W'(c) * BC_W'(BITS_PER_SYM);
      return t[POS_W-1:0];
   endfunction

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   assign armor   = dearmor(req_char_in);
   assign base    = POS_W'(req_start_bit - 1'b1);
   assign pos_div = div6(DIV_W'(base));
   assign grp_div = div6(DIV_W'(DIV_W'(req_field_bits) + DIV_W'(BITS_PER_SYM - 1)));
   assign ilen    = (req_field_bits > POS_W'(VALUE_W)) ? LEN_W'(VALUE_W)
                                                       : req_field_bits[LEN_W-1:0];

   always_comb begin
      nchars = req_max_chars;
      if (nchars > MAXC_W'(MAX_STRING_CHARS)) begin
         nchars = MAXC_W'(MAX_STRING_CHARS);
      end
      if (GRP_W'(nchars) > grp_div.quo) begin
         nchars = grp_div.quo[MAXC_W-1:0];
      end
   end

   // one bit of the walk
   always_comb begin
      bit_past  = pre_ff || (IDX_W'(count_ff) <= sym_idx_ff);
      bit_val   = bit_past ? 1'b0 : rd_ff[3'd5 - off_ff];
      past_next = past_ff | bit_past;
      acc_next  = {acc_ff[VALUE_W-2:0], bit_val};
      if (!is_str_ff && signed_ff && first_ff && bit_val) begin
         acc_next = '1;
      end
      text_next = {1'b0, acc_next[SYM_W-1:0]};
      if (acc_next[SYM_W-1:0] < TEXT_LIMIT) begin
         text_next = TEXT_W'(text_next + TEXT_RAISE);
      end
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      sym_idx_in    = sym_idx_ff;
      off_in        = off_ff;
      pre_in        = pre_ff;
      first_in      = first_ff;
      is_str_in     = is_str_ff;
      signed_in     = signed_ff;
      past_in       = past_ff;
      acc_in        = acc_ff;
      grp_left_in   = grp_left_ff;
      chars_left_in = chars_left_ff;
      rsp_valid_in  = 1'b0;
      rsp_value_in  = rsp_value_ff;
      rsp_text_in   = rsp_text_ff;
      rsp_cvalid_in = rsp_cvalid_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_bits_in   = rsp_bits_ff;
      rsp_status_in = rsp_status_ff;
      mem_we        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_value_in  = '0;
               rsp_text_in   = '0;
               rsp_cvalid_in = 1'b0;
               rsp_last_in   = 1'b1;
               rsp_bits_in   = bits_of(count_ff);
               rsp_status_in = STATUS_OK;
               pre_in        = (req_start_bit == '0);
               sym_idx_in    = (req_start_bit == '0) ? '0 : IDX_W'(pos_div.quo);
               off_in        = (req_start_bit == '0) ? '0 : pos_div.rem;
               first_in      = 1'b1;
               signed_in     = req_signed_flag;
               past_in       = 1'b0;
               acc_in        = '0;
               case (cmd_type'(req_command))
                  CMD_CLEAR: begin
                     count_in     = '0;
                     rsp_bits_in  = '0;
                     rsp_valid_in = 1'b1;
                  end
                  CMD_APPEND: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff >= CNT_W'(MAX_SYMBOLS)) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        mem_we        = 1'b1;
                        count_in      = CNT_W'(count_ff + 1'b1);
                        rsp_bits_in   = bits_of(CNT_W'(count_ff + 1'b1));
                        rsp_status_in = armor.bad ? STATUS_BAD_CHAR : STATUS_OK;
                     end
                  end
                  CMD_INT: begin
                     is_str_in   = 1'b0;
                     grp_left_in = ilen;
                     if (ilen == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = (req_start_bit == '0) ? ST_BITS : ST_FETCH;
                     end
                  end
                  CMD_STRING: begin
                     is_str_in     = 1'b1;
                     grp_left_in   = LEN_W'(BITS_PER_SYM);
                     chars_left_in = nchars;
                     if (nchars == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = (req_start_bit == '0) ? ST_BITS : ST_FETCH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FETCH: begin
            state_in = ST_BITS;
         end
         ST_BITS: begin
            acc_in      = acc_next;
            past_in     = past_next;
            first_in    = 1'b0;
            grp_left_in = LEN_W'(grp_left_ff - 1'b1);
            if (pre_ff) begin
               pre_in     = 1'b0;
               sym_idx_in = '0;
               off_in     = '0;
               state_in   = ST_FETCH;
            end else if (off_ff == 3'd5) begin
               sym_idx_in = IDX_W'(sym_idx_ff + 1'b1);
               off_in     = '0;
               state_in   = ST_FETCH;
            end else begin
               off_in   = 3'(off_ff + 1'b1);
               state_in = ST_BITS;
            end
            if (grp_left_ff == LEN_W'(1)) begin
               rsp_valid_in  = 1'b1;
               rsp_bits_in   = bits_of(count_ff);
               rsp_status_in = past_next ? STATUS_PAST : STATUS_OK;
               if (!is_str_ff) begin
                  rsp_value_in  = acc_next;
                  rsp_text_in   = '0;
                  rsp_cvalid_in = 1'b0;
                  rsp_last_in   = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  rsp_value_in  = '0;
                  rsp_text_in   = text_next;
                  rsp_cvalid_in = 1'b1;
                  rsp_last_in   = (chars_left_ff == MAXC_W'(1));
                  chars_left_in = MAXC_W'(chars_left_ff - 1'b1);
                  grp_left_in   = LEN_W'(BITS_PER_SYM);
                  acc_in        = '0;
                  past_in       = 1'b0;
                  if (chars_left_ff == MAXC_W'(1)) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      sym_idx_ff    <= sym_idx_in;
      off_ff        <= off_in;
      pre_ff        <= pre_in;
      first_ff      <= first_in;
      is_str_ff     <= is_str_in;
      signed_ff     <= signed_in;
      past_ff       <= past_in;
      acc_ff        <= acc_in;
      grp_left_ff   <= grp_left_in;
      chars_left_ff <= chars_left_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_text_ff   <= rsp_text_in;
      rsp_cvalid_ff <= rsp_cvalid_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_bits_ff   <= rsp_bits_in;
      rsp_status_ff <= rsp_status_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // symbol store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[count_ff[ADDR_W-1:0]] <= armor.sym;
      end
      if (state_ff == ST_FETCH) begin
         rd_ff <= mem[sym_idx_ff[ADDR_W-1:0]];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_value      = $signed(rsp_value_ff);
   assign rsp_text_char  = rsp_text_ff;
   assign rsp_char_valid = rsp_cvalid_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_bit_count  = rsp_bits_ff;
   assign rsp_status     = rsp_status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_SYMBOLS))
      else $error("symbol count beyond store depth");

   a_more_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_last_ff |-> busy)
      else $error("string walk stopped before its last character");

   a_clear_answer: assert property (@(posedge clock) disable iff (reset)
      accept && (req_command == CMD_CLEAR) |=> rsp_valid_ff && rsp_last_ff
         && (rsp_bits_ff == '0))
      else $error("clear not answered with an empty payload");

   a_text_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_cvalid_ff |-> (rsp_text_ff >= TEXT_MIN)
         && (rsp_text_ff <= TEXT_MAX))
      else $error("decoded character outside six-bit text range");

   a_walk_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BITS) |-> (grp_left_ff != '0))
      else $error("bit walk with no bits left");

endmodule
